FILE: rtl/multicore_priority_task_queue_steal_unit_assert.svh
// assertion macros for the task queue steal unit
// no dependencies; included by the modules that check their own logic
`ifndef MULTICORE_PRIORITY_TASK_QUEUE_STEAL_UNIT_ASSERT_SVH
`define MULTICORE_PRIORITY_TASK_QUEUE_STEAL_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define MPTQ_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mptq assertion failed");
// next-cycle implication
`define MPTQ_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mptq assertion failed");
`else
`define MPTQ_ASSERT_IMP(name, clk, rst, ante, cons)
`define MPTQ_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/mptq_pkg.sv
// shared types and constants of the task queue steal unit
// no dependencies
`default_nettype none
package mptq_pkg;

  localparam int CORE_CNT_DEF    = 16;
  localparam int PRIO_LEVELS_DEF = 4;
  localparam int TASK_SLOTS_DEF  = 256;
  // slots examined per cycle by the free slot search
  localparam int FM_GROUP        = 16;

  localparam logic [1:0] REQ_SUBMIT   = 2'd0;
  localparam logic [1:0] REQ_DISPATCH = 2'd1;
  localparam logic [1:0] REQ_CANCEL   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SUB_SCAN,
    S_MOD,
    S_SUB_QRD,
    S_SUB_LINK,
    S_SUB_FIX,
    S_DSP_QRD,
    S_DSP_QCHK,
    S_STL_QRD,
    S_STL_QCHK,
    S_UL_SWAIT,
    S_UL_W1,
    S_UL_W2,
    S_CAN_QRD,
    S_CAN_QCHK,
    S_CAN_SCHK,
    S_RESP
  } state_t;

  typedef enum logic {
    MOD_RR,
    MOD_VICTIM
  } mod_sel_t;

  // field write enables of the slot store
  typedef struct packed {
    logic id;
    logic prev;
    logic next;
  } slot_wen_t;

  // field write enables of the queue table
  typedef struct packed {
    logic head;
    logic tail;
    logic count;
  } queue_wen_t;

  // free slot search outcome
  typedef struct packed {
    logic done;
    logic found;
  } fm_res_t;

endpackage
`default_nettype wire

FILE: rtl/mptq_req_if.sv
// request channel of the task queue steal unit
// no dependencies
`default_nettype none
interface mptq_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic signed [4:0] pref_core;
  logic [1:0]        task_priority;
  logic [3:0]        requesting_core;
  logic [3:0]        victim_offset;
  logic [31:0]       cancel_id;

  modport source (output valid, req_type, pref_core, task_priority,
                  requesting_core, victim_offset, cancel_id, input ready);
  modport sink (input valid, req_type, pref_core, task_priority,
                requesting_core, victim_offset, cancel_id, output ready);
endinterface
`default_nettype wire

FILE: rtl/mptq_rsp_if.sv
// response channel of the task queue steal unit
// no dependencies
`default_nettype none
interface mptq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] task_id;
  logic [3:0]  task_core;
  logic [1:0]  out_priority;
  logic        was_stolen;

  modport source (output valid, status, task_id, task_core, out_priority,
                  was_stolen, input ready);
  modport sink (input valid, status, task_id, task_core, out_priority,
                was_stolen, output ready);
endinterface
`default_nettype wire

FILE: rtl/mptq_slot_mem.sv
// task slot store: id and list links per slot, one write and one read port
// depends on mptq_pkg
`default_nettype none
module mptq_slot_mem #(
  parameter int TASK_SLOTS = mptq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire mptq_pkg::slot_wen_t             wen,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]   waddr,
  input  wire logic [31:0]                     wid,
  input  wire logic [$clog2(TASK_SLOTS+1)-1:0] wprev,
  input  wire logic [$clog2(TASK_SLOTS+1)-1:0] wnext,
  input  wire logic [$clog2(TASK_SLOTS)-1:0]   raddr,
  output logic      [31:0]                     rid,
  output logic      [$clog2(TASK_SLOTS+1)-1:0] rprev,
  output logic      [$clog2(TASK_SLOTS+1)-1:0] rnext
);
  localparam int SW = $clog2(TASK_SLOTS + 1);

  logic [31:0]   id_mem   [TASK_SLOTS];
  logic [SW-1:0] prev_mem [TASK_SLOTS];
  logic [SW-1:0] next_mem [TASK_SLOTS];

  // per-field write
  always_ff @(posedge clk) begin
    if (wen.id) begin
      id_mem[waddr] <= wid;
    end
    if (wen.prev) begin
      prev_mem[waddr] <= wprev;
    end
    if (wen.next) begin
      next_mem[waddr] <= wnext;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rid   <= id_mem[raddr];
    rprev <= prev_mem[raddr];
    rnext <= next_mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/mptq_queue_mem.sv
// per core and level queue table: head, tail and count, with entry valid bits
// depends on mptq_pkg
`default_nettype none
module mptq_queue_mem #(
  parameter int NUM_QUEUES = mptq_pkg::CORE_CNT_DEF * mptq_pkg::PRIO_LEVELS_DEF,
  parameter int TASK_SLOTS = mptq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mptq_pkg::queue_wen_t            wen,
  input  wire logic [$clog2(NUM_QUEUES)-1:0]   addr,
  input  wire logic [$clog2(TASK_SLOTS+1)-1:0] whead,
  input  wire logic [$clog2(TASK_SLOTS+1)-1:0] wtail,
  input  wire logic [$clog2(TASK_SLOTS+1)-1:0] wcount,
  output logic      [$clog2(TASK_SLOTS+1)-1:0] rhead,
  output logic      [$clog2(TASK_SLOTS+1)-1:0] rtail,
  output logic      [$clog2(TASK_SLOTS+1)-1:0] rcount
);
  localparam int SW = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] NULL_S = SW'(TASK_SLOTS);

  logic [SW-1:0]         head_mem  [NUM_QUEUES];
  logic [SW-1:0]         tail_mem  [NUM_QUEUES];
  logic [SW-1:0]         count_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] valid;
  logic                  any_we;
  logic                  fresh;

  assign any_we = wen.head | wen.tail | wen.count;
  assign fresh  = !valid[addr];

  // an entry never written takes reset values in the fields not written
  always_ff @(posedge clk) begin
    if (wen.head || (any_we && fresh)) begin
      head_mem[addr] <= wen.head ? whead : NULL_S;
    end
    if (wen.tail || (any_we && fresh)) begin
      tail_mem[addr] <= wen.tail ? wtail : NULL_S;
    end
    if (wen.count || (any_we && fresh)) begin
      count_mem[addr] <= wen.count ? wcount : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (any_we) begin
      valid[addr] <= 1'b1;
    end
  end

  // registered read, invalid entries read as empty
  always_ff @(posedge clk) begin
    rhead  <= valid[addr] ? head_mem[addr]  : NULL_S;
    rtail  <= valid[addr] ? tail_mem[addr]  : NULL_S;
    rcount <= valid[addr] ? count_mem[addr] : '0;
  end
endmodule
`default_nettype wire

FILE: rtl/mptq_free_map.sv
// slot usage map with lowest-free search, one group of slots per cycle
// depends on mptq_pkg and the assertion macro header
`default_nettype none
`include "multicore_priority_task_queue_steal_unit_assert.svh"
module mptq_free_map #(
  parameter int TASK_SLOTS = mptq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          scan_start,
  input  wire logic                          set_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0] set_idx,
  input  wire logic                          clr_en,
  input  wire logic [$clog2(TASK_SLOTS)-1:0] clr_idx,
  output mptq_pkg::fm_res_t                  res,
  output logic      [$clog2(TASK_SLOTS)-1:0] slot
);
  localparam int GW  = mptq_pkg::FM_GROUP;
  localparam int NG  = (TASK_SLOTS + GW - 1) / GW;
  localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
  localparam int UD  = NG * GW;
  localparam int UIW = $clog2(UD);
  localparam int SIW = $clog2(TASK_SLOTS);
  localparam int EW  = $clog2(GW);

  logic [UD-1:0]  used;
  logic [UD-1:0]  free_vec;
  logic [GW-1:0]  grp;
  logic [EW-1:0]  enc;
  logic           grp_any;
  logic [GIW-1:0] g;
  logic           scanning;

  // slots past the store size never count as free
  always_comb begin
    for (int i = 0; i < UD; i++) begin
      free_vec[i] = !used[i] && (i < TASK_SLOTS);
    end
  end

  // lowest free slot of the current group
  always_comb begin
    grp = free_vec[UIW'(int'(g) * GW) +: GW];
    enc = '0;
    for (int i = GW - 1; i >= 0; i--) begin
      if (grp[i]) begin
        enc = EW'(i);
      end
    end
    grp_any = |grp;
  end

  assign res.found = scanning && grp_any;
  assign res.done  = scanning && (grp_any || g == GIW'(NG - 1));
  assign slot      = SIW'(int'(g) * GW + int'(enc));

  // group walk
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      g        <= '0;
    end else if (scan_start) begin
      scanning <= 1'b1;
      g        <= '0;
    end else if (scanning) begin
      if (res.done) begin
        scanning <= 1'b0;
      end else begin
        g <= g + 1'b1;
      end
    end
  end

  // usage bits
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      if (set_en) begin
        used[UIW'(set_idx)] <= 1'b1;
      end
      if (clr_en) begin
        used[UIW'(clr_idx)] <= 1'b0;
      end
    end
  end

  `MPTQ_ASSERT_IMP(a_set_free, clk, rst, set_en, !used[UIW'(set_idx)])
  `MPTQ_ASSERT_IMP(a_clr_used, clk, rst, clr_en, used[UIW'(clr_idx)])
  `MPTQ_ASSERT_NXT(a_set_sticks, clk, rst, set_en, used[UIW'($past(set_idx))])
endmodule
`default_nettype wire

FILE: rtl/multicore_priority_task_queue_steal_unit.sv
// top level of the task queue steal unit: control sequencer and result register
// depends on mptq_pkg, the channel interfaces, slot store, queue table, free map
//
// Use: requests come in on req (valid/ready). A submit gets the next 32-bit
// task ID and is appended to a per core and level FIFO; a dispatch pops the
// most urgent task of the requesting core or steals the tail of a victim core;
// a cancel removes a task by ID. Each submit, dispatch or cancel gives one
// transfer on rsp; an unknown request type is taken and gives none.
// cfg_we/cfg_index/cfg_wdata write active_cores (index 0) and
// steal_floor_prio (index 1); the user must write them only while the unit
// is idle, and nothing in the unit enforces this. One request at a time,
// all state in memories with registered reads:
//   submit   searches the free map group by group (groups of 16 slots), then
//            runs the round-robin reduction steps (none when the core is given)
//   dispatch reads the local levels, then for a steal runs the victim reduction
//            and reads the victim levels down to the floor, then unlinks
//   cancel   visits queues and compares tasks in each, then unlinks
// Reset empties all queues at once (entry valid bits), next ID 1, round-robin
// pointer 0. A finished result waits in the rsp register while the next
// request is taken; a stalled receiver holds it and the unit stops at the end
// of that request.
`default_nettype none
`include "multicore_priority_task_queue_steal_unit_assert.svh"
module multicore_priority_task_queue_steal_unit #(
  parameter int CORE_CNT    = mptq_pkg::CORE_CNT_DEF,
  parameter int PRIO_LEVELS = mptq_pkg::PRIO_LEVELS_DEF,
  parameter int TASK_SLOTS  = mptq_pkg::TASK_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [4:0] cfg_wdata,
  mptq_req_if.sink        req,
  mptq_rsp_if.source      rsp
);
  localparam int CW  = (CORE_CNT > 1) ? $clog2(CORE_CNT) : 1;
  localparam int CNW = $clog2(CORE_CNT + 1);
  localparam int MW  = (CNW > 4) ? CNW : 4;
  localparam int PW  = $clog2(PRIO_LEVELS);
  localparam int NQ  = CORE_CNT * PRIO_LEVELS;
  localparam int QIW = $clog2(NQ);
  localparam int SIW = $clog2(TASK_SLOTS);
  localparam int SW  = $clog2(TASK_SLOTS + 1);
  localparam logic [SW-1:0] NULL_S  = SW'(TASK_SLOTS);
  localparam logic [PW-1:0] LAST_P  = PW'(PRIO_LEVELS - 1);

  // configuration registers
  logic [4:0]     active_cores;
  logic [1:0]     steal_floor_prio;
  logic [CNW-1:0] cores_eff;
  logic [PW-1:0]  floor_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cores     <= 5'd16;
      steal_floor_prio <= 2'd1;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        active_cores <= cfg_wdata;
      end else begin
        steal_floor_prio <= cfg_wdata[1:0];
      end
    end
  end

  always_comb begin
    if (active_cores == '0) begin
      cores_eff = CNW'(1);
    end else if (int'(active_cores) > CORE_CNT) begin
      cores_eff = CNW'(CORE_CNT);
    end else begin
      cores_eff = CNW'(active_cores);
    end
    floor_eff = (int'(steal_floor_prio) > PRIO_LEVELS - 1) ? LAST_P
                                                            : PW'(steal_floor_prio);
  end

  // sequencer state and working registers
  mptq_pkg::state_t   state, state_next;
  mptq_pkg::mod_sel_t mod_sel, mod_sel_next;
  logic [CW-1:0]  cur_core, cur_core_next;
  logic [PW-1:0]  cur_p, cur_p_next;
  logic [3:0]     req_core, req_core_next;
  logic [3:0]     req_off, req_off_next;
  logic [PW-1:0]  sub_prio, sub_prio_next;
  logic [4:0]     sub_pref, sub_pref_next;
  logic [31:0]    want_id, want_id_next;
  logic [31:0]    next_id, next_id_next;
  logic [CW-1:0]  rr, rr_next;
  logic [SIW-1:0] s_cur, s_cur_next;
  logic [SW-1:0]  ul_prev, ul_prev_next;
  logic [SW-1:0]  ul_next, ul_next_next;
  logic [SW-1:0]  qc, qc_next;
  logic [MW-1:0]  mod_v, mod_v_next;
  logic [MW-1:0]  mod_d, mod_d_next;
  logic [1:0]     res_status, res_status_next;
  logic [31:0]    res_id, res_id_next;
  logic [3:0]     res_core, res_core_next;
  logic [1:0]     res_prio, res_prio_next;
  logic           res_stolen, res_stolen_next;

  // result register
  logic        out_valid;
  logic        out_load;
  logic [1:0]  out_status;
  logic [31:0] out_id;
  logic [3:0]  out_core;
  logic [1:0]  out_prio;
  logic        out_stolen;

  // memory controls
  mptq_pkg::queue_wen_t q_wen;
  logic [QIW-1:0]       q_addr;
  logic [SW-1:0]        q_whead, q_wtail, q_wcount;
  logic [SW-1:0]        q_rhead, q_rtail, q_rcount;
  mptq_pkg::slot_wen_t  s_wen;
  logic [SIW-1:0]       s_waddr, s_raddr;
  logic [31:0]          s_wid, s_rid;
  logic [SW-1:0]        s_wprev, s_wnext, s_rprev, s_rnext;
  logic                 fm_start, fm_set, fm_clr;
  mptq_pkg::fm_res_t    fm_res;
  logic [SIW-1:0]       fm_slot;

  logic        req_accept;
  logic        pref_ok;
  int          vic_sum;

  assign req.ready  = (state == mptq_pkg::S_IDLE);
  assign req_accept = req.valid && req.ready;
  assign q_addr     = QIW'(int'(cur_core) * PRIO_LEVELS + int'(cur_p));
  assign pref_ok    = !sub_pref[4] && (int'(sub_pref[3:0]) < int'(cores_eff));
  assign vic_sum    = int'(req_core) + 1 + int'(mod_v);

  mptq_queue_mem #(.NUM_QUEUES(NQ), .TASK_SLOTS(TASK_SLOTS)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wen    (q_wen),
    .addr   (q_addr),
    .whead  (q_whead),
    .wtail  (q_wtail),
    .wcount (q_wcount),
    .rhead  (q_rhead),
    .rtail  (q_rtail),
    .rcount (q_rcount)
  );

  mptq_slot_mem #(.TASK_SLOTS(TASK_SLOTS)) u_slot (
    .clk   (clk),
    .wen   (s_wen),
    .waddr (s_waddr),
    .wid   (s_wid),
    .wprev (s_wprev),
    .wnext (s_wnext),
    .raddr (s_raddr),
    .rid   (s_rid),
    .rprev (s_rprev),
    .rnext (s_rnext)
  );

  mptq_free_map #(.TASK_SLOTS(TASK_SLOTS)) u_free (
    .clk        (clk),
    .rst        (rst),
    .scan_start (fm_start),
    .set_en     (fm_set),
    .set_idx    (s_cur),
    .clr_en     (fm_clr),
    .clr_idx    (s_cur),
    .res        (fm_res),
    .slot       (fm_slot)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mptq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state outside the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= 32'd1;
      rr      <= '0;
    end else begin
      next_id <= next_id_next;
      rr      <= rr_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    mod_sel    <= mod_sel_next;
    cur_core   <= cur_core_next;
    cur_p      <= cur_p_next;
    req_core   <= req_core_next;
    req_off    <= req_off_next;
    sub_prio   <= sub_prio_next;
    sub_pref   <= sub_pref_next;
    want_id    <= want_id_next;
    s_cur      <= s_cur_next;
    ul_prev    <= ul_prev_next;
    ul_next    <= ul_next_next;
    qc         <= qc_next;
    mod_v      <= mod_v_next;
    mod_d      <= mod_d_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    res_core   <= res_core_next;
    res_prio   <= res_prio_next;
    res_stolen <= res_stolen_next;
  end

  // next state, working registers and memory controls
  always_comb begin
    state_next      = state;
    mod_sel_next    = mod_sel;
    cur_core_next   = cur_core;
    cur_p_next      = cur_p;
    req_core_next   = req_core;
    req_off_next    = req_off;
    sub_prio_next   = sub_prio;
    sub_pref_next   = sub_pref;
    want_id_next    = want_id;
    next_id_next    = next_id;
    rr_next         = rr;
    s_cur_next      = s_cur;
    ul_prev_next    = ul_prev;
    ul_next_next    = ul_next;
    qc_next         = qc;
    mod_v_next      = mod_v;
    mod_d_next      = mod_d;
    res_status_next = res_status;
    res_id_next     = res_id;
    res_core_next   = res_core;
    res_prio_next   = res_prio;
    res_stolen_next = res_stolen;

    q_wen    = '0;
    q_whead  = NULL_S;
    q_wtail  = NULL_S;
    q_wcount = '0;
    s_wen    = '0;
    s_waddr  = s_cur;
    s_wid    = next_id;
    s_wprev  = NULL_S;
    s_wnext  = NULL_S;
    s_raddr  = s_cur;
    fm_start = 1'b0;
    fm_set   = 1'b0;
    fm_clr   = 1'b0;
    out_load = 1'b0;

    unique case (state)
      mptq_pkg::S_IDLE: begin
        if (req_accept) begin
          req_core_next   = req.requesting_core;
          req_off_next    = req.victim_offset;
          sub_pref_next   = req.pref_core;
          want_id_next    = req.cancel_id;
          sub_prio_next   = (int'(req.task_priority) > PRIO_LEVELS - 1)
                            ? LAST_P : PW'(req.task_priority);
          res_status_next = mptq_pkg::STAT_OK;
          res_id_next     = '0;
          res_core_next   = '0;
          res_prio_next   = '0;
          res_stolen_next = 1'b0;
          unique case (req.req_type)
            mptq_pkg::REQ_SUBMIT: begin
              fm_start   = 1'b1;
              state_next = mptq_pkg::S_SUB_SCAN;
            end
            mptq_pkg::REQ_DISPATCH: begin
              if (int'(req.requesting_core) >= int'(cores_eff)) begin
                res_status_next = mptq_pkg::STAT_EMPTY;
                state_next      = mptq_pkg::S_RESP;
              end else begin
                cur_core_next = CW'(req.requesting_core);
                cur_p_next    = '0;
                state_next    = mptq_pkg::S_DSP_QRD;
              end
            end
            mptq_pkg::REQ_CANCEL: begin
              cur_core_next = '0;
              cur_p_next    = '0;
              state_next    = mptq_pkg::S_CAN_QRD;
            end
            default: begin
              state_next = mptq_pkg::S_IDLE;
            end
          endcase
        end
      end

      // lowest free slot, then the target core
      mptq_pkg::S_SUB_SCAN: begin
        if (fm_res.done) begin
          if (!fm_res.found) begin
            res_status_next = mptq_pkg::STAT_FULL;
            state_next      = mptq_pkg::S_RESP;
          end else begin
            s_cur_next = fm_slot;
            cur_p_next = sub_prio;
            if (pref_ok) begin
              cur_core_next = CW'(sub_pref[3:0]);
              state_next    = mptq_pkg::S_SUB_QRD;
            end else begin
              mod_v_next   = MW'(rr);
              mod_d_next   = MW'(cores_eff);
              mod_sel_next = mptq_pkg::MOD_RR;
              state_next   = mptq_pkg::S_MOD;
            end
          end
        end
      end

      // remainder by repeated subtraction
      mptq_pkg::S_MOD: begin
        if (mod_v >= mod_d) begin
          mod_v_next = mod_v - mod_d;
        end else if (mod_sel == mptq_pkg::MOD_RR) begin
          cur_core_next = CW'(mod_v);
          rr_next       = (int'(mod_v) + 1 >= int'(cores_eff)) ? '0 : CW'(mod_v + 1'b1);
          state_next    = mptq_pkg::S_SUB_QRD;
        end else begin
          cur_core_next = (vic_sum >= int'(cores_eff)) ? CW'(vic_sum - int'(cores_eff))
                                                       : CW'(vic_sum);
          cur_p_next    = LAST_P;
          state_next    = mptq_pkg::S_STL_QRD;
        end
      end

      mptq_pkg::S_SUB_QRD: begin
        state_next = mptq_pkg::S_SUB_LINK;
      end

      // append at the tail
      mptq_pkg::S_SUB_LINK: begin
        s_wen     = '{id: 1'b1, prev: 1'b1, next: 1'b1};
        s_waddr   = s_cur;
        s_wid     = next_id;
        s_wprev   = q_rtail;
        s_wnext   = NULL_S;
        q_wen     = '{head: (q_rtail == NULL_S), tail: 1'b1, count: 1'b1};
        q_whead   = SW'(s_cur);
        q_wtail   = SW'(s_cur);
        q_wcount  = q_rcount + 1'b1;
        fm_set    = 1'b1;
        res_id_next   = next_id;
        res_core_next = 4'(cur_core);
        res_prio_next = 2'(cur_p);
        next_id_next  = next_id + 32'd1;
        ul_prev_next  = q_rtail;
        state_next    = (q_rtail == NULL_S) ? mptq_pkg::S_RESP : mptq_pkg::S_SUB_FIX;
      end

      mptq_pkg::S_SUB_FIX: begin
        s_wen      = '{id: 1'b0, prev: 1'b0, next: 1'b1};
        s_waddr    = SIW'(ul_prev);
        s_wnext    = SW'(s_cur);
        state_next = mptq_pkg::S_RESP;
      end

      // local levels, most urgent first
      mptq_pkg::S_DSP_QRD: begin
        state_next = mptq_pkg::S_DSP_QCHK;
      end

      mptq_pkg::S_DSP_QCHK: begin
        if (q_rhead != NULL_S) begin
          s_raddr         = SIW'(q_rhead);
          s_cur_next      = SIW'(q_rhead);
          qc_next         = q_rcount;
          res_stolen_next = 1'b0;
          state_next      = mptq_pkg::S_UL_SWAIT;
        end else if (cur_p != LAST_P) begin
          cur_p_next = cur_p + 1'b1;
          state_next = mptq_pkg::S_DSP_QRD;
        end else if (int'(cores_eff) <= 1) begin
          res_status_next = mptq_pkg::STAT_EMPTY;
          state_next      = mptq_pkg::S_RESP;
        end else begin
          mod_v_next   = MW'(req_off);
          mod_d_next   = MW'(cores_eff) - 1'b1;
          mod_sel_next = mptq_pkg::MOD_VICTIM;
          state_next   = mptq_pkg::S_MOD;
        end
      end

      // victim levels, least urgent first down to the floor
      mptq_pkg::S_STL_QRD: begin
        state_next = mptq_pkg::S_STL_QCHK;
      end

      mptq_pkg::S_STL_QCHK: begin
        if (q_rcount > SW'(1) && q_rtail != NULL_S) begin
          s_raddr         = SIW'(q_rtail);
          s_cur_next      = SIW'(q_rtail);
          qc_next         = q_rcount;
          res_stolen_next = 1'b1;
          state_next      = mptq_pkg::S_UL_SWAIT;
        end else if (cur_p == floor_eff) begin
          res_status_next = mptq_pkg::STAT_EMPTY;
          state_next      = mptq_pkg::S_RESP;
        end else begin
          cur_p_next = cur_p - 1'b1;
          state_next = mptq_pkg::S_STL_QRD;
        end
      end

      mptq_pkg::S_UL_SWAIT: begin
        ul_prev_next = s_rprev;
        ul_next_next = s_rnext;
        res_id_next  = s_rid;
        state_next   = mptq_pkg::S_UL_W1;
      end

      // unlink: predecessor and queue ends
      mptq_pkg::S_UL_W1: begin
        s_wen    = '{id: 1'b0, prev: 1'b0, next: (ul_prev != NULL_S)};
        s_waddr  = SIW'(ul_prev);
        s_wnext  = ul_next;
        q_wen    = '{head: (ul_prev == NULL_S), tail: (ul_next == NULL_S), count: 1'b1};
        q_whead  = ul_next;
        q_wtail  = ul_prev;
        q_wcount = (qc != '0) ? qc - 1'b1 : '0;
        fm_clr   = 1'b1;
        res_core_next = 4'(cur_core);
        res_prio_next = 2'(cur_p);
        state_next    = (ul_next == NULL_S) ? mptq_pkg::S_RESP : mptq_pkg::S_UL_W2;
      end

      // unlink: successor
      mptq_pkg::S_UL_W2: begin
        s_wen      = '{id: 1'b0, prev: 1'b1, next: 1'b0};
        s_waddr    = SIW'(ul_next);
        s_wprev    = ul_prev;
        state_next = mptq_pkg::S_RESP;
      end

      // cancel walk over cores, levels and list entries
      mptq_pkg::S_CAN_QRD: begin
        state_next = mptq_pkg::S_CAN_QCHK;
      end

      mptq_pkg::S_CAN_QCHK: begin
        qc_next = q_rcount;
        if (q_rhead != NULL_S) begin
          s_raddr    = SIW'(q_rhead);
          s_cur_next = SIW'(q_rhead);
          state_next = mptq_pkg::S_CAN_SCHK;
        end else if (cur_p != LAST_P) begin
          cur_p_next = cur_p + 1'b1;
          state_next = mptq_pkg::S_CAN_QRD;
        end else if (int'(cur_core) == int'(cores_eff) - 1) begin
          res_status_next = mptq_pkg::STAT_NOT_FOUND;
          state_next      = mptq_pkg::S_RESP;
        end else begin
          cur_core_next = cur_core + 1'b1;
          cur_p_next    = '0;
          state_next    = mptq_pkg::S_CAN_QRD;
        end
      end

      mptq_pkg::S_CAN_SCHK: begin
        if (s_rid == want_id) begin
          ul_prev_next = s_rprev;
          ul_next_next = s_rnext;
          res_id_next  = s_rid;
          state_next   = mptq_pkg::S_UL_W1;
        end else if (s_rnext != NULL_S) begin
          s_raddr    = SIW'(s_rnext);
          s_cur_next = SIW'(s_rnext);
        end else if (cur_p != LAST_P) begin
          cur_p_next = cur_p + 1'b1;
          state_next = mptq_pkg::S_CAN_QRD;
        end else if (int'(cur_core) == int'(cores_eff) - 1) begin
          res_status_next = mptq_pkg::STAT_NOT_FOUND;
          state_next      = mptq_pkg::S_RESP;
        end else begin
          cur_core_next = cur_core + 1'b1;
          cur_p_next    = '0;
          state_next    = mptq_pkg::S_CAN_QRD;
        end
      end

      // hand the result to the output register
      mptq_pkg::S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = mptq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mptq_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_id     <= (res_status == mptq_pkg::STAT_OK) ? res_id : '0;
      out_core   <= (res_status == mptq_pkg::STAT_OK) ? res_core : '0;
      out_prio   <= (res_status == mptq_pkg::STAT_OK) ? res_prio : '0;
      out_stolen <= (res_status == mptq_pkg::STAT_OK) && res_stolen;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.task_id      = out_id;
  assign rsp.task_core    = out_core;
  assign rsp.out_priority = out_prio;
  assign rsp.was_stolen   = out_stolen;

  `MPTQ_ASSERT_IMP(a_load_free, clk, rst, out_load, !out_valid || rsp.ready)
  `MPTQ_ASSERT_IMP(a_unlink_count, clk, rst, state == mptq_pkg::S_UL_W1, qc != '0)
  `MPTQ_ASSERT_NXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid)
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// testbench of the multicore priority task queue steal unit: random and directed requests
// depends on mptq_pkg, mptq_req_if, mptq_rsp_if and the unit's top level
`default_nettype none
module tb;

  localparam int CORES = 16;
  localparam int LVLS  = 4;
  localparam int SLOTS = 256;
  localparam int NQ    = CORES * LVLS;
  localparam int NUL   = SLOTS;
  localparam int SETTLE = 800;

  localparam logic CFG_ACTIVE_CORES = 1'b0;
  localparam logic CFG_STEAL_FLOOR  = 1'b1;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]        kind;
    logic signed [4:0] pref;
    logic [1:0]        prio;
    logic [3:0]        rcore;
    logic [3:0]        voff;
    logic [31:0]       cid;
  } task_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] id;
    logic [3:0]  core;
    logic [1:0]  prio;
    logic        stolen;
  } task_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_wdata = '0;

  mptq_req_if req_ch ();
  mptq_rsp_if rsp_ch ();

  multicore_priority_task_queue_steal_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .req(req_ch), .rsp(rsp_ch)
  );

  always #2 clk = ~clk;

  // predicted queue state
  logic [31:0] slot_tid [SLOTS];
  int          slot_prv [SLOTS];
  int          slot_nxt [SLOTS];
  bit          slot_busy [SLOTS];
  int          q_head [NQ];
  int          q_tail [NQ];
  int          q_cnt [NQ];
  logic [31:0] next_tid;
  int          rr_ptr;
  int          active_cores;
  int          steal_floor;

  task_req_t   pending_reqs [$];
  task_rsp_t   expected_rsps [$];
  int          n_accepted = 0;
  int          n_errors = 0;

  function automatic int eff_cores();
    if (active_cores < 1) return 1;
    if (active_cores > CORES) return CORES;
    return active_cores;
  endfunction

  function automatic void unlink_task(int q, int s);
    int p, n;
    p = slot_prv[s];
    n = slot_nxt[s];
    if (p < NUL) slot_nxt[p] = n; else q_head[q] = n;
    if (n < NUL) slot_prv[n] = p; else q_tail[q] = p;
    if (q_cnt[q] > 0) q_cnt[q]--;
    slot_busy[s] = 1'b0;
  endfunction

  function automatic task_rsp_t rsp_of(logic [1:0] st, logic [31:0] id, int core,
                                       int prio, bit stolen);
    task_rsp_t r;
    r.status = st;
    r.id = id;
    r.core = core[3:0];
    r.prio = prio[1:0];
    r.stolen = stolen;
    return r;
  endfunction

  // computes the result of one accepted request and updates the queues
  function automatic void predict_request(task_req_t r);
    int cores, s, tgt, q, p, victim, flr;
    int pref;
    cores = eff_cores();
    case (r.kind)
      mptq_pkg::REQ_SUBMIT: begin
        pref = r.pref;
        s = NUL;
        for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) s = i;
        if (s >= NUL) begin
          expected_rsps.push_back(rsp_of(mptq_pkg::STAT_FULL, '0, 0, 0, 0));
        end else begin
          if (pref >= 0 && pref < cores) begin
            tgt = pref;
          end else begin
            tgt = rr_ptr % cores;
            rr_ptr = (tgt + 1 >= cores) ? 0 : tgt + 1;
          end
          q = tgt * LVLS + r.prio;
          slot_busy[s] = 1'b1;
          slot_tid[s] = next_tid;
          slot_nxt[s] = NUL;
          slot_prv[s] = q_tail[q];
          if (q_tail[q] < NUL) slot_nxt[q_tail[q]] = s; else q_head[q] = s;
          q_tail[q] = s;
          q_cnt[q]++;
          expected_rsps.push_back(rsp_of(mptq_pkg::STAT_OK, next_tid, tgt, r.prio, 0));
          next_tid = next_tid + 1;
        end
      end
      mptq_pkg::REQ_DISPATCH: begin
        if (r.rcore >= cores) begin
          expected_rsps.push_back(rsp_of(mptq_pkg::STAT_EMPTY, '0, 0, 0, 0));
          return;
        end
        // local pop, most urgent level first
        for (p = 0; p < LVLS; p++) begin
          q = r.rcore * LVLS + p;
          s = q_head[q];
          if (s < NUL) begin
            expected_rsps.push_back(rsp_of(mptq_pkg::STAT_OK, slot_tid[s], r.rcore, p, 0));
            unlink_task(q, s);
            return;
          end
        end
        if (cores <= 1) begin
          expected_rsps.push_back(rsp_of(mptq_pkg::STAT_EMPTY, '0, 0, 0, 0));
          return;
        end
        // steal the tail of the victim, least urgent level first
        victim = (r.rcore + 1 + r.voff % (cores - 1)) % cores;
        flr = steal_floor;
        for (p = LVLS - 1; p >= flr; p--) begin
          q = victim * LVLS + p;
          if (q_cnt[q] > 1 && q_tail[q] < NUL) begin
            s = q_tail[q];
            expected_rsps.push_back(rsp_of(mptq_pkg::STAT_OK, slot_tid[s], victim, p, 1));
            unlink_task(q, s);
            return;
          end
        end
        expected_rsps.push_back(rsp_of(mptq_pkg::STAT_EMPTY, '0, 0, 0, 0));
      end
      mptq_pkg::REQ_CANCEL: begin
        for (int c = 0; c < cores; c++) begin
          for (p = 0; p < LVLS; p++) begin
            q = c * LVLS + p;
            s = q_head[q];
            while (s < NUL) begin
              if (slot_tid[s] == r.cid) begin
                unlink_task(q, s);
                expected_rsps.push_back(rsp_of(mptq_pkg::STAT_OK, r.cid, c, p, 0));
                return;
              end
              s = slot_nxt[s];
            end
          end
        end
        expected_rsps.push_back(rsp_of(mptq_pkg::STAT_NOT_FOUND, '0, 0, 0, 0));
      end
      default: ;
    endcase
  endfunction

  // idle rates by stage of the run
  function automatic int send_idle_pct();
    if (n_accepted < 170) return 30;
    if (n_accepted < 340) return 87;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_accepted < 170) return 87;
    if (n_accepted < 340) return 30;
    return 0;
  endfunction

  // request driver
  task_req_t cur_req;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_request(cur_req);
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_req = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.req_type <= cur_req.kind;
          req_ch.pref_core <= cur_req.pref;
          req_ch.task_priority <= cur_req.prio;
          req_ch.requesting_core <= cur_req.rcore;
          req_ch.victim_offset <= cur_req.voff;
          req_ch.cancel_id <= cur_req.cid;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with one long hold-off so the unit backs up
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  task_rsp_t exp_r;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer status=%0d id=%0h", $time,
                   rsp_ch.status, rsp_ch.task_id);
          n_errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (rsp_ch.status !== exp_r.status || rsp_ch.task_id !== exp_r.id ||
              rsp_ch.task_core !== exp_r.core || rsp_ch.out_priority !== exp_r.prio ||
              rsp_ch.was_stolen !== exp_r.stolen) begin
            $display("%0t: mismatch expected st=%0d id=%0h core=%0d prio=%0d stolen=%0d",
                     $time, exp_r.status, exp_r.id, exp_r.core, exp_r.prio, exp_r.stolen);
            $display("%0t:          actual   st=%0d id=%0h core=%0d prio=%0d stolen=%0d",
                     $time, rsp_ch.status, rsp_ch.task_id, rsp_ch.task_core,
                     rsp_ch.out_priority, rsp_ch.was_stolen);
            n_errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        rsp_ch.ready <= 1'b0;
      end else if (!hold_done && n_accepted >= 150) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct());
      end
    end
  end

  function automatic task_req_t mk_req(logic [1:0] kind, int pref, int prio, int rcore,
                                       int voff, logic [31:0] cid);
    task_req_t r;
    r.kind = kind;
    r.pref = pref[4:0];
    r.prio = prio[1:0];
    r.rcore = rcore[3:0];
    r.voff = voff[3:0];
    r.cid = cid;
    return r;
  endfunction

  // random request; cancels mostly aim at recently issued IDs
  function automatic task_req_t rand_req(int sub_pct, int dsp_pct);
    int roll;
    logic [31:0] cid;
    roll = $urandom_range(99);
    if ($urandom_range(3) == 0) cid = $urandom;
    else cid = next_tid + pending_reqs.size() - $urandom_range(1, 60);
    if (roll < sub_pct)
      return mk_req(mptq_pkg::REQ_SUBMIT, $urandom_range(31), $urandom_range(3), 0, 0, 0);
    if (roll < sub_pct + dsp_pct)
      return mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, $urandom_range(15), $urandom_range(15), 0);
    if (roll < 97)
      return mk_req(mptq_pkg::REQ_CANCEL, $urandom_range(31), $urandom_range(3),
                    $urandom_range(15), $urandom_range(15), cid);
    return mk_req(REQ_UNKNOWN, $urandom_range(31), $urandom_range(3), $urandom_range(15),
                  $urandom_range(15), $urandom);
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[4:0];
    if (idx == CFG_ACTIVE_CORES) active_cores = val & 31;
    else steal_floor = val & 3;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int sub_pct, int dsp_pct);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(sub_pct, dsp_pct));
    drain();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_tid[i] = '0;
      slot_prv[i] = 0;
      slot_nxt[i] = 0;
    end
    for (int i = 0; i < NQ; i++) begin
      q_head[i] = NUL;
      q_tail[i] = NUL;
      q_cnt[i] = 0;
    end
    next_tid = 32'd1;
    rr_ptr = 0;
    active_cores = 16;
    steal_floor = 1;
    req_ch.valid = 1'b0;
    req_ch.req_type = mptq_pkg::REQ_SUBMIT;
    req_ch.pref_core = '0;
    req_ch.task_priority = '0;
    req_ch.requesting_core = '0;
    req_ch.victim_offset = '0;
    req_ch.cancel_id = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: given core, round-robin, local pop, steal, cancel, unknown type
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 15, 3, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, -1, 1, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, -16, 2, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 2, 3, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 2, 3, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 2, 3, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, 2, 1, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 5, 11, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 15, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 14, 15, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_CANCEL, 0, 0, 0, 0, 32'd6));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_CANCEL, 0, 0, 0, 0, 32'd0));
    pending_reqs.push_back(mk_req(REQ_UNKNOWN, 15, 3, 15, 15, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 1, 0, 0));
    pending_reqs.push_back(mk_req(mptq_pkg::REQ_DISPATCH, 0, 0, 1, 0, 0));
    drain();

    random_phase(60, 45, 38);

    // few cores, stealing down to the most urgent level
    write_cfg(CFG_ACTIVE_CORES, 3);
    write_cfg(CFG_STEAL_FLOOR, 0);
    random_phase(50, 45, 40);

    // zero saturates to a single core; top floor scans only the least urgent level
    write_cfg(CFG_ACTIVE_CORES, 0);
    write_cfg(CFG_STEAL_FLOOR, 3);
    random_phase(30, 45, 40);

    // above range saturates to all cores; fill the store past full, then run mostly dispatches
    write_cfg(CFG_ACTIVE_CORES, 31);
    write_cfg(CFG_STEAL_FLOOR, 2);
    for (int i = 0; i < 265; i++)
      pending_reqs.push_back(mk_req(mptq_pkg::REQ_SUBMIT, $urandom_range(31),
                                    $urandom_range(3), 0, 0, 0));
    random_phase(40, 15, 55);

    write_cfg(CFG_ACTIVE_CORES, 16);
    write_cfg(CFG_STEAL_FLOOR, 1);
    random_phase(40, 45, 38);

    if (n_errors == 0) begin
      $display("multicore_priority_task_queue_steal_unit test passed");
    end else begin
      $display("multicore_priority_task_queue_steal_unit test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("multicore_priority_task_queue_steal_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire
